// ===== rtl/core/fbc16_pkg.sv =====
// Types, tables and round functions for the 16-bit Feistel block cipher.
package fbc16_pkg;

   localparam int BLK_W = 16;
   localparam int HALF_W = 8;
   localparam int KEY_W = 16;
   localparam int SUBKEY_W = 12;
   localparam int CNT_W = 4;
   localparam int KIDX_W = 3;
   localparam int MAX_ROUNDS_DEF = 8;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_CIPHER_KEY = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROUND_COUNT = 1'b1;

   localparam logic [3:0] IP_TAB [16] =
      '{4'd13, 4'd9, 4'd5, 4'd1, 4'd15, 4'd11, 4'd7, 4'd3,
        4'd12, 4'd8, 4'd4, 4'd0, 4'd14, 4'd10, 4'd6, 4'd2};
   localparam logic [3:0] FP_TAB [16] =
      '{4'd11, 4'd3, 4'd15, 4'd7, 4'd10, 4'd2, 4'd14, 4'd6,
        4'd9, 4'd1, 4'd13, 4'd5, 4'd8, 4'd0, 4'd12, 4'd4};
   localparam logic [2:0] E_TAB [12] =
      '{3'd7, 3'd0, 3'd1, 3'd2, 3'd2, 3'd3, 3'd4, 3'd5, 3'd5, 3'd6, 3'd7, 3'd0};
   // P table stored zero-based.
   localparam logic [2:0] P_TAB [8] =
      '{3'd5, 3'd4, 3'd7, 3'd6, 3'd3, 3'd2, 3'd0, 3'd1};
   localparam logic [1:0] SBOX_TAB [4][4][2] = '{
      '{'{2'd0, 2'd2}, '{2'd1, 2'd3}, '{2'd3, 2'd0}, '{2'd2, 2'd1}},
      '{'{2'd0, 2'd3}, '{2'd2, 2'd0}, '{2'd1, 2'd2}, '{2'd3, 2'd1}},
      '{'{2'd1, 2'd0}, '{2'd3, 2'd2}, '{2'd2, 2'd3}, '{2'd0, 2'd1}},
      '{'{2'd3, 2'd2}, '{2'd1, 2'd0}, '{2'd1, 2'd0}, '{2'd2, 2'd3}}};
   localparam logic [3:0] PC1_TAB [14] =
      '{4'd6, 4'd4, 4'd11, 4'd5, 4'd1, 4'd2, 4'd0,
        4'd14, 4'd12, 4'd13, 4'd9, 4'd3, 4'd10, 4'd8};
   localparam logic [3:0] PC2_TAB [12] =
      '{4'd6, 4'd4, 4'd2, 4'd5, 4'd0, 4'd1, 4'd12, 4'd13, 4'd10, 4'd9, 4'd11, 4'd7};
   localparam logic [1:0] SHIFT_TAB [8] =
      '{2'd1, 2'd2, 2'd2, 2'd1, 2'd1, 2'd2, 2'd2, 2'd1};

   typedef struct packed {
      logic [HALF_W-1:0] left;
      logic [HALF_W-1:0] right;
      logic              decrypt;
   } stage_data_type;

   function automatic logic [BLK_W-1:0] perm_ip(input logic [BLK_W-1:0] src);
      logic [BLK_W-1:0] r;
      for (int i = 0; i < BLK_W; i++) r[i] = src[IP_TAB[i]];
      return r;
   endfunction

   function automatic logic [BLK_W-1:0] perm_fp(input logic [BLK_W-1:0] src);
      logic [BLK_W-1:0] r;
      for (int i = 0; i < BLK_W; i++) r[i] = src[FP_TAB[i]];
      return r;
   endfunction

   function automatic logic [6:0] rot7(input logic [6:0] h, input logic [1:0] s);
      logic [6:0] r;
      logic [3:0] idx;
      for (int i = 0; i < 7; i++) begin
         idx = 4'(i) + {2'b00, s};
         if (idx >= 4'd7) idx = idx - 4'd7;
         r[i] = h[idx[2:0]];
      end
      return r;
   endfunction

   function automatic logic [SUBKEY_W-1:0] subkey(input logic [KEY_W-1:0] key,
                                                  input logic [KIDX_W-1:0] j);
      logic [13:0] k14;
      logic [13:0] rk;
      logic [SUBKEY_W-1:0] r;
      for (int i = 0; i < 14; i++) k14[i] = key[PC1_TAB[i]];
      rk = {rot7(k14[13:7], SHIFT_TAB[j]), rot7(k14[6:0], SHIFT_TAB[j])};
      for (int i = 0; i < SUBKEY_W; i++) r[i] = rk[PC2_TAB[i]];
      return r;
   endfunction

   function automatic logic [HALF_W-1:0] round_f(input logic [HALF_W-1:0] r8,
                                                 input logic [SUBKEY_W-1:0] k12);
      logic [SUBKEY_W-1:0] x;
      logic [HALF_W-1:0] s8;
      logic [HALF_W-1:0] r;
      logic [2:0] g;
      for (int i = 0; i < SUBKEY_W; i++) x[i] = r8[E_TAB[i]];
      x = x ^ k12;
      for (int b = 0; b < 4; b++) begin
         g = x[3*b +: 3];
         s8[2*b +: 2] = SBOX_TAB[b][{g[0], g[2]}][g[1]];
      end
      for (int i = 0; i < HALF_W; i++) r[i] = s8[P_TAB[i]];
      return r;
   endfunction

endpackage

// ===== rtl/core/feistel_block_cipher_16bit.sv =====
// Top level of the 16-bit DES-style Feistel block cipher pipeline.
//
// A transaction on the req_ channel carries one 16-bit block and a decrypt flag;
// each one yields exactly one transaction on the rsp_ channel with the result,
// in order. Both channels use valid/ready.
// The key and the round count are set through the csr_ write port (index 0 is
// the key, index 1 the round count, which saturates at MAX_ROUNDS). They must
// only be written while no transaction is in flight.
// The core is a chain of MAX_ROUNDS round cells, each holding one block in a
// stage register. A block moves from cell to cell through these registers in
// order, and the chain accepts one block every cycle while the receiver does
// not stall. Cells beyond the round count pass the block through unchanged, so
// latency does not depend on it.
// When the receiver stalls, the last cell holds its result and each cell keeps
// accepting until it is full; req_ready falls only once every cell holds a block.
// Reset clears all stage valid bits, sets the key to zero and the round count
// to eight; the block is ready (req_ready high) as soon as reset is released.
module feistel_block_cipher_16bit
   import fbc16_pkg::*;
#(
   parameter int MAX_ROUNDS = MAX_ROUNDS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [BLK_W-1:0]      req_block_in,
   input  logic                  req_decrypt,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [BLK_W-1:0]      rsp_block_out
);

   logic [KEY_W-1:0]  cipher_key_ff;
   logic [CNT_W-1:0]  round_count_ff;
   logic [CNT_W-1:0]  rounds;
   logic [BLK_W-1:0]  ip_out;

   logic              valid_chain [MAX_ROUNDS+1];
   logic              ready_chain [MAX_ROUNDS+1];
   stage_data_type    data_chain [MAX_ROUNDS+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         cipher_key_ff <= '0;
         round_count_ff <= CNT_W'(MAX_ROUNDS_DEF);
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_CIPHER_KEY: cipher_key_ff <= csr_wdata[KEY_W-1:0];
            CSR_ROUND_COUNT: round_count_ff <= csr_wdata[CNT_W-1:0];
            default: ;
         endcase
      end
   end

   assign rounds = (round_count_ff > CNT_W'(MAX_ROUNDS)) ? CNT_W'(MAX_ROUNDS)
                                                         : round_count_ff;

   assign ip_out = perm_ip(req_block_in);
   assign valid_chain[0] = req_valid;
   assign req_ready = ready_chain[0];
   assign data_chain[0] = '{left: ip_out[HALF_W-1:0],
                            right: ip_out[BLK_W-1:HALF_W],
                            decrypt: req_decrypt};

   for (genvar g = 0; g < MAX_ROUNDS; g++) begin : g_cell
      fbc16_cell #(
         .STAGE(g)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .cipher_key (cipher_key_ff),
         .rounds     (rounds),
         .up_valid   (valid_chain[g]),
         .up_ready   (ready_chain[g]),
         .up_data    (data_chain[g]),
         .dn_valid   (valid_chain[g+1]),
         .dn_ready   (ready_chain[g+1]),
         .dn_data    (data_chain[g+1])
      );
   end

   assign rsp_valid = valid_chain[MAX_ROUNDS];
   assign ready_chain[MAX_ROUNDS] = rsp_ready;
   assign rsp_block_out = perm_fp({data_chain[MAX_ROUNDS].left,
                                   data_chain[MAX_ROUNDS].right});

endmodule

// ===== rtl/core/fbc16_cell.sv =====
// One Feistel round cell of the pipeline with its own valid/ready stage register.
module fbc16_cell
   import fbc16_pkg::*;
#(
   parameter int STAGE = 0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [KEY_W-1:0]     cipher_key,
   input  logic [CNT_W-1:0]     rounds,
   input  logic                 up_valid,
   output logic                 up_ready,
   input  stage_data_type       up_data,
   output logic                 dn_valid,
   input  logic                 dn_ready,
   output stage_data_type       dn_data
);

   logic                valid_ff;
   logic                valid_in;
   stage_data_type      data_ff;
   stage_data_type      data_in;
   logic                active;
   logic [CNT_W-1:0]    kidx_full;
   logic [KIDX_W-1:0]   kidx;
   logic [HALF_W-1:0]   f_out;

   assign up_ready = !valid_ff || dn_ready;
   assign valid_in = up_ready ? up_valid : valid_ff;

   always_comb begin
      active = CNT_W'(STAGE) < rounds;
      kidx_full = up_data.decrypt ? (rounds - CNT_W'(1) - CNT_W'(STAGE)) : CNT_W'(STAGE);
      kidx = kidx_full[KIDX_W-1:0];
      f_out = round_f(up_data.right, subkey(cipher_key, kidx));
      data_in = up_data;
      if (active) begin
         data_in.left = up_data.right;
         data_in.right = up_data.left ^ f_out;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         data_ff <= data_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_data = data_ff;

endmodule
